// ===== hw/rtl/cas_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CEC audio-system responder: shared types and constants
// Beat formats, configuration and state records, event kinds, CEC opcodes
// and infrared key codes used across the responder.
// ----------------------------------------------------------------------------
package cas_pkg;

    // Width of the one-shot delay counter
    localparam int DELAY_WIDTH = 16;

    // Result queue depth and derived widths
    localparam int FIFO_DEPTH = 4;
    localparam int PTR_W      = $clog2(FIFO_DEPTH);
    localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DELAY_TICKS  = 2'd0,
        CFG_VENDOR_ID    = 2'd1,
        CFG_VERSION_BYTE = 2'd2,
        CFG_OWN_ADDRESS  = 2'd3
    } cfg_index_t;

    localparam logic [15:0] DELAY_TICKS_RST  = 16'd4000;
    localparam logic [23:0] VENDOR_ID_RST    = 24'h180399;
    localparam logic [7:0]  VERSION_BYTE_RST = 8'h05;
    localparam logic [3:0]  OWN_ADDRESS_RST  = 4'd5;

    // Event kinds carried in the input opcode field
    typedef enum logic [1:0] {
        EV_CEC_FRAME = 2'd0,
        EV_BUTTON    = 2'd1,
        EV_TICK      = 2'd2,
        EV_UNUSED    = 2'd3
    } event_kind_t;

    // CEC opcodes
    localparam logic [7:0] OP_ABORT        = 8'h00;
    localparam logic [7:0] OP_STANDBY      = 8'h36;
    localparam logic [7:0] OP_UC_PRESSED   = 8'h44;
    localparam logic [7:0] OP_UC_RELEASED  = 8'h45;
    localparam logic [7:0] OP_AUDIO_REQ    = 8'h70;
    localparam logic [7:0] OP_SET_AUDIO    = 8'h72;
    localparam logic [7:0] OP_GIVE_PHYS    = 8'h83;
    localparam logic [7:0] OP_REPORT_PHYS  = 8'h84;
    localparam logic [7:0] OP_VENDOR       = 8'h87;
    localparam logic [7:0] OP_GIVE_VENDOR  = 8'h8C;
    localparam logic [7:0] OP_GIVE_POWER   = 8'h8F;
    localparam logic [7:0] OP_REPORT_POWER = 8'h90;
    localparam logic [7:0] OP_VERSION      = 8'h9E;
    localparam logic [7:0] OP_GET_VERSION  = 8'h9F;

    // User-control codes that map to infrared keys on release
    localparam logic [7:0] UC_VOL_UP   = 8'h41;
    localparam logic [7:0] UC_VOL_DOWN = 8'h42;
    localparam logic [7:0] UC_MUTE     = 8'h43;
    localparam logic [7:0] UC_NONE     = 8'hFF;

    // Power status payload
    localparam logic [7:0] PWR_STATUS_ON  = 8'h00;
    localparam logic [7:0] PWR_STATUS_OFF = 8'h01;
    localparam logic [7:0] AUDIO_MODE_ON  = 8'h01;
    localparam logic [7:0] ABORT_REASON   = 8'h00;

    localparam logic [3:0] ADDR_BCAST = 4'd15;

    typedef enum logic [2:0] {
        KEY_PWR    = 3'd0,
        KEY_VUP    = 3'd1,
        KEY_VDN    = 3'd2,
        KEY_MUTE   = 3'd3,
        KEY_VIDEO2 = 3'd4
    } ir_key_t;

    localparam logic RK_IR    = 1'b0;
    localparam logic RK_FRAME = 1'b1;

    typedef struct packed {
        logic [1:0] opcode;
        logic [3:0] cec_source;
        logic       is_polling;
        logic [7:0] cec_opcode;
        logic [7:0] operand_byte;
    } cas_in_t;

    typedef struct packed {
        logic       result_kind;
        logic [2:0] ir_key;
        logic [3:0] frame_target;
        logic [7:0] frame_opcode;
        logic [1:0] payload_len;
        logic [7:0] payload_first;
        logic [7:0] payload_second;
        logic [7:0] payload_third;
        logic       last;
    } cas_out_t;

    typedef struct packed {
        logic [15:0] delay_ticks;
        logic [23:0] vendor_id;
        logic [7:0]  version_byte;
        logic [3:0]  own_address;
    } cas_cfg_t;

    typedef struct packed {
        logic                   power_on;
        logic [7:0]             held_control;
        logic [DELAY_WIDTH-1:0] delay_left;
        logic                   delay_running;
    } cas_state_t;

endpackage

// ===== hw/rtl/cec_audio_system_responder_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CEC audio-system responder
// Turns received CEC frames, button presses and ticks into CEC reply frames
// and infrared key beats.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready/in_data) takes one event beat: a CEC
//   frame, a local button press or a time tick. Output channel
//   (out_valid/out_ready/out_data) delivers zero, one or two result beats
//   per event, in order; the last one of an event has last set.
//   An accepted event is held in the input register, where its results
//   are decoded and pushed into a four-beat result queue at the next edge;
//   the first result is driven to the output from the head of the queue.
//   Events are taken back to back while the queue can hold two beats for
//   every pending event; with the receiver always ready, the single output
//   port sets the sustained event rate.
//   When the receiver stalls, beats stay in the queue and in_ready drops
//   once the queue cannot hold the worst case of the pending events.
//   Configuration writes (cfg_we/cfg_index/cfg_wdata) take effect at once;
//   the user makes them only while the block is idle, unenforced here.
//   Reset clears the queue, powers the amplifier flag off, stops the delay
//   counter and restores the configuration defaults.
// ----------------------------------------------------------------------------
module cec_audio_system_responder_core
    import cas_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  cas_in_t               in_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output cas_out_t              out_data,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    cas_in_t          item_reg;
    logic             item_valid_reg;
    logic             item_valid_next;
    cas_state_t       state_reg;
    cas_state_t       state_next;
    cas_state_t       dec_state;
    cas_cfg_t         cfg_reg;
    cas_cfg_t         cfg_next;
    cas_out_t         res0;
    cas_out_t         res1;
    logic [1:0]       res_cnt;
    logic [1:0]       push_cnt;
    logic [CNT_W-1:0] fifo_count;
    logic [CNT_W+1:0] need;
    logic             in_fire;

    // Admit an event only when the queue can take the worst case
    always_comb
    begin
        need = (CNT_W + 2)'(fifo_count) + (CNT_W + 2)'(2)
             + (item_valid_reg ? (CNT_W + 2)'(2) : '0);
        in_ready = (need <= (CNT_W + 2)'(FIFO_DEPTH));
    end

    assign in_fire         = in_valid && in_ready;
    assign item_valid_next = in_fire;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
        end
        else
        begin
            item_valid_reg <= item_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            item_reg <= in_data;
        end
    end

    // Configuration registers
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_DELAY_TICKS:  cfg_next.delay_ticks  = cfg_wdata[15:0];
                CFG_VENDOR_ID:    cfg_next.vendor_id    = cfg_wdata[23:0];
                CFG_VERSION_BYTE: cfg_next.version_byte = cfg_wdata[7:0];
                CFG_OWN_ADDRESS:  cfg_next.own_address  = cfg_wdata[3:0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.delay_ticks  <= DELAY_TICKS_RST;
            cfg_reg.vendor_id    <= VENDOR_ID_RST;
            cfg_reg.version_byte <= VERSION_BYTE_RST;
            cfg_reg.own_address  <= OWN_ADDRESS_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Decode the registered event
    cas_decode u_decode (
        .item       (item_reg),
        .state      (state_reg),
        .cfg        (cfg_reg),
        .state_next (dec_state),
        .res0       (res0),
        .res1       (res1),
        .res_cnt    (res_cnt)
    );

    // Commit state and push results only for a live event
    always_comb
    begin
        state_next = item_valid_reg ? dec_state : state_reg;
        push_cnt   = item_valid_reg ? res_cnt : 2'd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.power_on      <= 1'b0;
            state_reg.held_control  <= UC_NONE;
            state_reg.delay_left    <= '0;
            state_reg.delay_running <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    cas_result_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_cnt   (push_cnt),
        .push0      (res0),
        .push1      (res1),
        .pop        (out_ready),
        .head_valid (out_valid),
        .head       (out_data),
        .count      (fifo_count)
    );

    // Queue never overfills
    a_fifo_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fifo_count <= CNT_W'(FIFO_DEPTH))
        else $error("result queue over capacity");

    // A live event always finds room for its results
    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid_reg |-> ((CNT_W + 1)'(fifo_count) + (CNT_W + 1)'(res_cnt)
                            <= (CNT_W + 1)'(FIFO_DEPTH)))
        else $error("result push without room");

    // A running delay counter never holds zero
    a_delay_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.delay_running |-> (state_reg.delay_left != '0))
        else $error("delay counter running at zero");

    // An accepted event is decoded in the next cycle
    a_accept_decode: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> item_valid_reg)
        else $error("accepted event not registered");

    // Power flag changes only while an event is decoded
    a_power_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !item_valid_reg |=> $stable(state_reg.power_on))
        else $error("power flag changed without an event");

endmodule

// ===== hw/rtl/cas_decode.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CEC audio-system responder: event decode
// Maps one registered event and the current state to up to two result
// beats and the next state.
// ----------------------------------------------------------------------------
module cas_decode
    import cas_pkg::*;
(
    input  cas_in_t    item,
    input  cas_state_t state,
    input  cas_cfg_t   cfg,
    output cas_state_t state_next,
    output cas_out_t   res0,
    output cas_out_t   res1,
    output logic [1:0] res_cnt
);

    function automatic cas_out_t mk_ir(input ir_key_t key);
        cas_out_t r;
        r             = '0;
        r.result_kind = RK_IR;
        r.ir_key      = key;
        return r;
    endfunction

    function automatic cas_out_t mk_frame(input logic [3:0] target,
                                          input logic [7:0] op,
                                          input logic [1:0] len,
                                          input logic [7:0] b0,
                                          input logic [7:0] b1,
                                          input logic [7:0] b2);
        cas_out_t r;
        r                = '0;
        r.result_kind    = RK_FRAME;
        r.frame_target   = target;
        r.frame_opcode   = op;
        r.payload_len    = len;
        r.payload_first  = b0;
        r.payload_second = b1;
        r.payload_third  = b2;
        return r;
    endfunction

    logic [DELAY_WIDTH-1:0] arm_value;
    logic [DELAY_WIDTH-1:0] left_dec;
    cas_out_t               r0;
    cas_out_t               r1;
    logic [1:0]             n;

    // Arm value: masked delay, zero counts as one tick
    always_comb
    begin
        arm_value = DELAY_WIDTH'(cfg.delay_ticks);
        if (arm_value == '0)
        begin
            arm_value = DELAY_WIDTH'(1);
        end
        left_dec = state.delay_left - DELAY_WIDTH'(1);
    end

    // Event handling
    always_comb
    begin
        state_next = state;
        r0         = '0;
        r1         = '0;
        n          = 2'd0;
        unique case (event_kind_t'(item.opcode))
            EV_BUTTON:
            begin
                r0 = mk_ir(KEY_PWR);
                n  = 2'd1;
                if (!state.power_on)
                begin
                    state_next.power_on      = 1'b1;
                    state_next.delay_left    = arm_value;
                    state_next.delay_running = 1'b1;
                end
                else
                begin
                    state_next.power_on = 1'b0;
                end
            end
            EV_TICK:
            begin
                if (state.delay_running)
                begin
                    state_next.delay_left = left_dec;
                    if (left_dec == '0)
                    begin
                        state_next.delay_running = 1'b0;
                        r0 = mk_ir(KEY_VIDEO2);
                        n  = 2'd1;
                    end
                end
            end
            EV_CEC_FRAME:
            begin
                if (!item.is_polling)
                begin
                    unique case (item.cec_opcode)
                        OP_STANDBY:
                        begin
                            if (state.power_on)
                            begin
                                state_next.power_on = 1'b0;
                                r0 = mk_ir(KEY_PWR);
                                n  = 2'd1;
                            end
                        end
                        OP_GIVE_PHYS:
                        begin
                            r0 = mk_frame(item.cec_source, OP_REPORT_PHYS, 2'd1,
                                          {4'd0, cfg.own_address}, 8'd0, 8'd0);
                            n  = 2'd1;
                        end
                        OP_GET_VERSION:
                        begin
                            r0 = mk_frame(item.cec_source, OP_VERSION, 2'd1,
                                          cfg.version_byte, 8'd0, 8'd0);
                            n  = 2'd1;
                        end
                        OP_GIVE_VENDOR:
                        begin
                            r0 = mk_frame(item.cec_source, OP_VENDOR, 2'd3,
                                          cfg.vendor_id[23:16], cfg.vendor_id[15:8],
                                          cfg.vendor_id[7:0]);
                            n  = 2'd1;
                        end
                        OP_GIVE_POWER:
                        begin
                            r0 = mk_frame(item.cec_source, OP_REPORT_POWER, 2'd1,
                                          state.power_on ? PWR_STATUS_ON : PWR_STATUS_OFF,
                                          8'd0, 8'd0);
                            n  = 2'd1;
                        end
                        OP_UC_PRESSED:
                        begin
                            state_next.held_control = item.operand_byte;
                        end
                        OP_AUDIO_REQ:
                        begin
                            if (!state.power_on)
                            begin
                                state_next.power_on      = 1'b1;
                                state_next.delay_left    = arm_value;
                                state_next.delay_running = 1'b1;
                                r0 = mk_ir(KEY_PWR);
                                r1 = mk_frame(ADDR_BCAST, OP_SET_AUDIO, 2'd1,
                                              AUDIO_MODE_ON, 8'd0, 8'd0);
                                n  = 2'd2;
                            end
                            else
                            begin
                                r0 = mk_frame(ADDR_BCAST, OP_SET_AUDIO, 2'd1,
                                              AUDIO_MODE_ON, 8'd0, 8'd0);
                                n  = 2'd1;
                            end
                        end
                        OP_UC_RELEASED:
                        begin
                            priority if (state.held_control == UC_VOL_UP)
                            begin
                                r0 = mk_ir(KEY_VUP);
                                n  = 2'd1;
                            end
                            else if (state.held_control == UC_VOL_DOWN)
                            begin
                                r0 = mk_ir(KEY_VDN);
                                n  = 2'd1;
                            end
                            else if (state.held_control == UC_MUTE)
                            begin
                                r0 = mk_ir(KEY_MUTE);
                                n  = 2'd1;
                            end
                            else
                            begin
                                n = 2'd0;
                            end
                        end
                        OP_ABORT:
                        begin
                            n = 2'd0;
                        end
                        default:
                        begin
                            r0 = mk_frame(item.cec_source, OP_ABORT, 2'd1,
                                          ABORT_REASON, 8'd0, 8'd0);
                            n  = 2'd1;
                        end
                    endcase
                end
            end
            default:
            begin
                n = 2'd0;
            end
        endcase

        // Flag the final beat of this event
        if (n == 2'd1)
        begin
            r0.last = 1'b1;
        end
        if (n == 2'd2)
        begin
            r1.last = 1'b1;
        end
    end

    assign res0    = r0;
    assign res1    = r1;
    assign res_cnt = n;

endmodule

// ===== hw/rtl/cas_result_fifo.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CEC audio-system responder: result queue
// Small queue that takes up to two result beats per cycle and hands one
// beat per cycle to the output channel while the receiver is ready.
// ----------------------------------------------------------------------------
module cas_result_fifo
    import cas_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic [1:0]       push_cnt,
    input  cas_out_t         push0,
    input  cas_out_t         push1,
    input  logic             pop,
    output logic             head_valid,
    output cas_out_t         head,
    output logic [CNT_W-1:0] count
);

    cas_out_t         mem [FIFO_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_pop;

    assign do_pop = pop && (count_reg != '0);

    // Advance pointers and occupancy
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + PTR_W'(push_cnt);
        rd_ptr_next = rd_ptr_reg + PTR_W'(do_pop);
        count_next  = count_reg + CNT_W'(push_cnt) - CNT_W'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store pushed beats in order
    always_ff @(posedge clk)
    begin
        if (push_cnt != 2'd0)
        begin
            mem[wr_ptr_reg] <= push0;
        end
        if (push_cnt == 2'd2)
        begin
            mem[wr_ptr_reg + PTR_W'(1)] <= push1;
        end
    end

    assign head_valid = (count_reg != '0);
    assign head       = mem[rd_ptr_reg];
    assign count      = count_reg;

endmodule

// ===== test/cec_audio_system_responder_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CEC audio-system responder: self-checking testbench
// Sends CEC frames, button presses and ticks through the event channel and
// checks every reply beat against an in-bench prediction of the responder:
// power flag, held user-control code, the one-shot input-select delay and
// the configuration registers. Directed checks come first, then random
// traffic under several register settings and idling patterns.
// ----------------------------------------------------------------------------
module cec_audio_system_responder_core_tb;
    import cas_pkg::*;

    localparam int SETTLE_CYCLES  = 8;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int PHASE_EVENTS   = 265;
    localparam int DRAIN_EVERY    = 90;

    // Opcodes the responder knows, for well-formed random frames
    localparam logic [7:0] KNOWN_OPS [10] = '{
        OP_STANDBY, OP_GIVE_PHYS, OP_GET_VERSION, OP_GIVE_VENDOR, OP_GIVE_POWER,
        OP_UC_PRESSED, OP_UC_PRESSED, OP_UC_RELEASED, OP_AUDIO_REQ, OP_ABORT
    };

    logic                  clk;
    logic                  rst_n     = 1'b0;
    logic                  in_valid  = 1'b0;
    logic                  in_ready;
    cas_in_t               in_data   = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    cas_out_t              out_data;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    // Predicted responder state and register copy
    cas_cfg_t               cfg_shadow;
    logic                   amp_on;
    logic [7:0]             held_uc;
    logic [DELAY_WIDTH-1:0] delay_cnt;
    logic                   delay_armed;

    // Reply beats still owed by the responder, oldest first
    cas_out_t replies_due [$];

    int snd_idle_pct  = 0;
    int rcv_stall_pct = 0;
    int events_sent   = 0;
    int beats_checked = 0;
    int ir_beats      = 0;
    int frame_beats   = 0;
    int mismatches    = 0;
    int idle_cycles   = 0;

    cec_audio_system_responder_core DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Build an infrared key beat
    function automatic cas_out_t ir_beat(input ir_key_t key);
        cas_out_t b;
        b = '0;
        b.result_kind = RK_IR;
        b.ir_key      = key;
        return b;
    endfunction

    // Build a CEC frame beat
    function automatic cas_out_t frame_beat(input logic [3:0] target,
                                            input logic [7:0] op,
                                            input logic [1:0] len,
                                            input logic [7:0] b0,
                                            input logic [7:0] b1,
                                            input logic [7:0] b2);
        cas_out_t b;
        b = '0;
        b.result_kind    = RK_FRAME;
        b.frame_target   = target;
        b.frame_opcode   = op;
        b.payload_len    = len;
        b.payload_first  = b0;
        b.payload_second = b1;
        b.payload_third  = b2;
        return b;
    endfunction

    // Load the delay counter; a zero setting after masking counts as one tick
    function automatic void arm_delay_timer();
        delay_cnt = DELAY_WIDTH'(cfg_shadow.delay_ticks);
        if (delay_cnt == '0)
            delay_cnt = DELAY_WIDTH'(1);
        delay_armed = 1'b1;
    endfunction

    // Advance the predicted state by one event and queue the beats it owes
    function automatic void derive_replies(input cas_in_t ev);
        cas_out_t beats [2];
        int       n;
        n = 0;
        case (ev.opcode)
            EV_BUTTON:
            begin
                beats[n++] = ir_beat(KEY_PWR);
                if (!amp_on)
                begin
                    amp_on = 1'b1;
                    arm_delay_timer();
                end
                else
                    amp_on = 1'b0;
            end
            EV_TICK:
            begin
                if (delay_armed)
                begin
                    delay_cnt = delay_cnt - 1'b1;
                    if (delay_cnt == '0)
                    begin
                        delay_armed = 1'b0;
                        beats[n++]  = ir_beat(KEY_VIDEO2);
                    end
                end
            end
            EV_CEC_FRAME:
            begin
                if (!ev.is_polling)
                begin
                    case (ev.cec_opcode)
                        OP_STANDBY:
                        begin
                            if (amp_on)
                            begin
                                amp_on     = 1'b0;
                                beats[n++] = ir_beat(KEY_PWR);
                            end
                        end
                        OP_GIVE_PHYS:
                            beats[n++] = frame_beat(ev.cec_source, OP_REPORT_PHYS, 2'd1,
                                                    {4'd0, cfg_shadow.own_address},
                                                    8'd0, 8'd0);
                        OP_GET_VERSION:
                            beats[n++] = frame_beat(ev.cec_source, OP_VERSION, 2'd1,
                                                    cfg_shadow.version_byte, 8'd0, 8'd0);
                        OP_GIVE_VENDOR:
                            beats[n++] = frame_beat(ev.cec_source, OP_VENDOR, 2'd3,
                                                    cfg_shadow.vendor_id[23:16],
                                                    cfg_shadow.vendor_id[15:8],
                                                    cfg_shadow.vendor_id[7:0]);
                        OP_GIVE_POWER:
                            beats[n++] = frame_beat(ev.cec_source, OP_REPORT_POWER, 2'd1,
                                                    amp_on ? PWR_STATUS_ON : PWR_STATUS_OFF,
                                                    8'd0, 8'd0);
                        OP_UC_PRESSED:
                            held_uc = ev.operand_byte;
                        OP_AUDIO_REQ:
                        begin
                            if (!amp_on)
                            begin
                                amp_on     = 1'b1;
                                beats[n++] = ir_beat(KEY_PWR);
                                arm_delay_timer();
                            end
                            beats[n++] = frame_beat(ADDR_BCAST, OP_SET_AUDIO, 2'd1,
                                                    AUDIO_MODE_ON, 8'd0, 8'd0);
                        end
                        OP_UC_RELEASED:
                        begin
                            if (held_uc == UC_VOL_UP)
                                beats[n++] = ir_beat(KEY_VUP);
                            else if (held_uc == UC_VOL_DOWN)
                                beats[n++] = ir_beat(KEY_VDN);
                            else if (held_uc == UC_MUTE)
                                beats[n++] = ir_beat(KEY_MUTE);
                        end
                        OP_ABORT: ;
                        default:
                            beats[n++] = frame_beat(ev.cec_source, OP_ABORT, 2'd1,
                                                    ABORT_REASON, 8'd0, 8'd0);
                    endcase
                end
            end
            default: ;
        endcase
        if (n > 0)
            beats[n-1].last = 1'b1;
        for (int i = 0; i < n; i++)
            replies_due.push_back(beats[i]);
    endfunction

    function automatic cas_in_t mk_event(input event_kind_t kind, input logic [3:0] src,
                                         input logic polling, input logic [7:0] op,
                                         input logic [7:0] arg);
        cas_in_t ev;
        ev.opcode       = kind;
        ev.cec_source   = src;
        ev.is_polling   = polling;
        ev.cec_opcode   = op;
        ev.operand_byte = arg;
        return ev;
    endfunction

    // Mostly well-formed traffic, with some noise mixed in
    function automatic cas_in_t random_event();
        cas_in_t     ev;
        int unsigned pick;
        ev   = cas_in_t'($bits(cas_in_t)'($urandom));
        pick = $urandom_range(99);
        ev.is_polling = 1'b0;
        if (pick < 55)
        begin
            ev.opcode     = EV_CEC_FRAME;
            ev.cec_opcode = KNOWN_OPS[$urandom_range(9)];
            if (ev.cec_opcode == OP_UC_PRESSED && $urandom_range(99) < 70)
                ev.operand_byte = UC_VOL_UP + 8'($urandom_range(2));
        end
        else if (pick < 67)
            ev.opcode = EV_BUTTON;
        else if (pick < 87)
            ev.opcode = EV_TICK;
        else if (pick < 93)
            ev.opcode = EV_CEC_FRAME;
        else if (pick < 97)
        begin
            ev.opcode     = EV_CEC_FRAME;
            ev.is_polling = 1'b1;
        end
        else
        begin
            ev.opcode     = EV_UNUSED;
            ev.is_polling = 1'($urandom);
        end
        return ev;
    endfunction

    // Present one event beat and hold it until it is taken
    task automatic send_event(input cas_in_t ev);
        while ($urandom_range(99) < snd_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= ev;
        do
            @(posedge clk);
        while (!in_ready);
        derive_replies(ev);
        events_sent++;
        @(negedge clk);
    endtask

    // Stop sending and wait for every owed beat, then let the pipeline empty
    task automatic hold_until_drained();
        in_valid <= 1'b0;
        while (replies_due.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // Write all four registers while the responder is idle
    task automatic write_config(input cas_cfg_t c);
        cfg_index_t idx;
        hold_until_drained();
        for (int i = 0; i < 4; i++)
        begin
            idx = cfg_index_t'(i);
            cfg_we    <= 1'b1;
            cfg_index <= idx;
            case (idx)
                CFG_DELAY_TICKS:  cfg_wdata <= {8'($urandom), c.delay_ticks};
                CFG_VENDOR_ID:    cfg_wdata <= c.vendor_id;
                CFG_VERSION_BYTE: cfg_wdata <= {16'($urandom), c.version_byte};
                default:          cfg_wdata <= {20'($urandom), c.own_address};
            endcase
            @(negedge clk);
        end
        cfg_we     <= 1'b0;
        cfg_shadow  = c;
    endtask

    // Queries, ignored frames and unknown opcodes with reset registers
    task automatic test_query_replies();
        send_event(mk_event(EV_CEC_FRAME, 4'd0,  1'b0, OP_GIVE_PHYS,   8'h00));
        send_event(mk_event(EV_CEC_FRAME, 4'd15, 1'b0, OP_GET_VERSION, 8'hFF));
        send_event(mk_event(EV_CEC_FRAME, 4'd4,  1'b0, OP_GIVE_VENDOR, 8'h5A));
        send_event(mk_event(EV_CEC_FRAME, 4'd1,  1'b0, OP_GIVE_POWER,  8'h00));
        send_event(mk_event(EV_CEC_FRAME, 4'd9,  1'b1, OP_GIVE_PHYS,   8'h00));
        send_event(mk_event(EV_CEC_FRAME, 4'd2,  1'b0, OP_ABORT,       8'h00));
        send_event(mk_event(EV_CEC_FRAME, 4'd15, 1'b0, 8'hFF,          8'hFF));
        send_event(mk_event(EV_UNUSED,    4'd15, 1'b1, 8'hFF,          8'hFF));
        send_event(mk_event(EV_TICK,      4'd0,  1'b0, 8'h00,          8'h00));
        send_event(mk_event(EV_CEC_FRAME, 4'd3,  1'b0, OP_STANDBY,     8'h00));
    endtask

    // Power toggling, delayed input select and re-arming
    task automatic test_power_and_delay();
        cas_cfg_t c;
        c = cfg_shadow;
        c.delay_ticks = 16'd2;
        write_config(c);
        send_event(mk_event(EV_CEC_FRAME, 4'd7, 1'b0, OP_AUDIO_REQ,  8'h00));
        send_event(mk_event(EV_CEC_FRAME, 4'd7, 1'b0, OP_AUDIO_REQ,  8'h00));
        send_event(mk_event(EV_CEC_FRAME, 4'd8, 1'b0, OP_GIVE_POWER, 8'h00));
        send_event(mk_event(EV_CEC_FRAME, 4'd0, 1'b0, OP_STANDBY,    8'h00));
        send_event(mk_event(EV_TICK,      4'd0, 1'b0, 8'h00,         8'h00));
        send_event(mk_event(EV_TICK,      4'd0, 1'b0, 8'h00,         8'h00));
        send_event(mk_event(EV_BUTTON,    4'd0, 1'b0, 8'h00,         8'h00));
        send_event(mk_event(EV_TICK,      4'd0, 1'b0, 8'h00,         8'h00));
        send_event(mk_event(EV_BUTTON,    4'd0, 1'b0, 8'h00,         8'h00));
        send_event(mk_event(EV_BUTTON,    4'd0, 1'b0, 8'h00,         8'h00));
        send_event(mk_event(EV_TICK,      4'd0, 1'b0, 8'h00,         8'h00));
        send_event(mk_event(EV_TICK,      4'd0, 1'b0, 8'h00,         8'h00));
    endtask

    // Key release maps held volume and mute codes; the held code persists
    task automatic test_key_release();
        send_event(mk_event(EV_CEC_FRAME, 4'd0, 1'b0, OP_UC_RELEASED, 8'h00));
        send_event(mk_event(EV_CEC_FRAME, 4'd0, 1'b0, OP_UC_PRESSED,  UC_VOL_UP));
        send_event(mk_event(EV_CEC_FRAME, 4'd0, 1'b0, OP_UC_RELEASED, 8'h00));
        send_event(mk_event(EV_CEC_FRAME, 4'd0, 1'b0, OP_UC_RELEASED, 8'h00));
        send_event(mk_event(EV_CEC_FRAME, 4'd0, 1'b0, OP_UC_PRESSED,  UC_VOL_DOWN));
        send_event(mk_event(EV_CEC_FRAME, 4'd0, 1'b0, OP_UC_RELEASED, 8'h00));
        send_event(mk_event(EV_CEC_FRAME, 4'd0, 1'b0, OP_UC_PRESSED,  UC_MUTE));
        send_event(mk_event(EV_CEC_FRAME, 4'd0, 1'b0, OP_UC_RELEASED, 8'h00));
    endtask

    // Zero delay acts as one tick; register maxima show up in the replies
    task automatic test_register_extremes();
        write_config('{16'd0, 24'hFFFFFF, 8'hFF, 4'hF});
        send_event(mk_event(EV_BUTTON,    4'd0, 1'b0, 8'h00,          8'h00));
        send_event(mk_event(EV_BUTTON,    4'd0, 1'b0, 8'h00,          8'h00));
        send_event(mk_event(EV_TICK,      4'd0, 1'b0, 8'h00,          8'h00));
        send_event(mk_event(EV_CEC_FRAME, 4'd6, 1'b0, OP_GIVE_VENDOR, 8'h00));
        send_event(mk_event(EV_CEC_FRAME, 4'd6, 1'b0, OP_GET_VERSION, 8'h00));
        send_event(mk_event(EV_CEC_FRAME, 4'd6, 1'b0, OP_GIVE_PHYS,   8'h00));
    endtask

    // Random traffic under one register setting and one idling pattern
    task automatic test_random_traffic(input cas_cfg_t c, input int snd_pct,
                                       input int rcv_pct);
        write_config(c);
        snd_idle_pct  = snd_pct;
        rcv_stall_pct = rcv_pct;
        for (int i = 1; i <= PHASE_EVENTS; i++)
        begin
            send_event(random_event());
            if (i % DRAIN_EVERY == 0)
                hold_until_drained();
        end
    endtask

    // Receiver back-pressure
    always @(negedge clk)
        out_ready <= ($urandom_range(99) >= rcv_stall_pct);

    task automatic compare_field(input string name, input int unsigned want,
                                 input int unsigned got);
        if (want != got)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            mismatches++;
        end
    endtask

    // Check each reply beat against the oldest one owed
    always @(posedge clk)
    begin : check_beat
        cas_out_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (replies_due.size() == 0)
            begin
                $error("reply beat with nothing owed: 0x%0h", out_data);
                mismatches++;
            end
            else
            begin
                want = replies_due.pop_front();
                compare_field("result_kind",    want.result_kind,    out_data.result_kind);
                compare_field("ir_key",         want.ir_key,         out_data.ir_key);
                compare_field("frame_target",   want.frame_target,   out_data.frame_target);
                compare_field("frame_opcode",   want.frame_opcode,   out_data.frame_opcode);
                compare_field("payload_len",    want.payload_len,    out_data.payload_len);
                compare_field("payload_first",  want.payload_first,  out_data.payload_first);
                compare_field("payload_second", want.payload_second, out_data.payload_second);
                compare_field("payload_third",  want.payload_third,  out_data.payload_third);
                compare_field("last",           want.last,           out_data.last);
                beats_checked++;
                if (want.result_kind == RK_IR)
                    ir_beats++;
                else
                    frame_beats++;
            end
        end
    end

    // Watchdog: give up when no beat moves for too long
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    initial
    begin
        cfg_shadow  = '{DELAY_TICKS_RST, VENDOR_ID_RST, VERSION_BYTE_RST, OWN_ADDRESS_RST};
        amp_on      = 1'b0;
        held_uc     = UC_NONE;
        delay_cnt   = '0;
        delay_armed = 1'b0;

        repeat (6) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_query_replies();
        test_power_and_delay();
        test_key_release();
        test_register_extremes();

        test_random_traffic('{16'd3, 24'($urandom), 8'($urandom), 4'($urandom)}, 0, 0);
        test_random_traffic('{16'hFFFF, 24'hFFFFFF, 8'hFF, 4'hF}, 53, 0);
        test_random_traffic('{16'd1, 24'h000000, 8'h00, 4'h0}, 0, 53);
        test_random_traffic('{16'($urandom_range(6, 1)), 24'($urandom), 8'($urandom),
                              4'($urandom)}, 36, 36);

        hold_until_drained();
        if (replies_due.size() != 0)
            mismatches++;

        $display("covered %0d events and %0d reply beats (%0d infrared keys, %0d frames)",
                 events_sent, beats_checked, ir_beats, frame_beats);
        $display("directed queries, power, delay and key cases, then four idling phases");
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

// ===== sim.f =====
hw/rtl/cas_pkg.sv
hw/rtl/cas_decode.sv
hw/rtl/cas_result_fifo.sv
hw/rtl/cec_audio_system_responder_core.sv
test/cec_audio_system_responder_core_tb.sv
